>>> rtl/lphs_pkg.sv
`default_nettype none
package lphs_pkg;

    localparam int KEY_W    = 64;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [1:0] {
        REQ_FIND   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUP       = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // slot marks; the fourth code is never written and reads as a tombstone
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_DEAD  = 2'd2;

    // hash select codes
    localparam logic [1:0] HS_IDENT  = 2'd0;
    localparam logic [1:0] HS_FIB    = 2'd1;
    localparam logic [1:0] HS_MURMUR = 2'd2;
    localparam logic [1:0] HS_FNV    = 2'd3;
    localparam logic [1:0] HS_RESET  = HS_MURMUR;

    localparam logic [63:0] C_FIB      = 64'd11400714819323198485;
    localparam logic [63:0] C_MUR1     = 64'hff51afd7ed558ccd;
    localparam logic [63:0] C_MUR2     = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] C_FNV_OFF  = 64'hcbf29ce484222325;
    localparam logic [63:0] C_FNV_PRM  = 64'h00000100000001b3;
    localparam int          MUR_SHIFT  = 33;

    typedef enum logic [3:0] {
        H_IDLE,
        H_XS,
        H_FNVX,
        H_MUL,
        H_MOD,
        H_DONE,
        H_FOLD,
        H_RCP,
        H_QM,
        H_FIX
    } t_hash_state;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> rtl/lphs_if.sv
`default_nettype none
interface lphs_req_if import lphs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;

    modport source (output valid, req_type, key, payload, input ready);
    modport sink   (input valid, req_type, key, payload, output ready);
endinterface

interface lphs_rsp_if import lphs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAY_W-1:0]    found_payload;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, found_payload, entry_count, input ready);
    modport sink   (input valid, status, found_payload, entry_count, output ready);
endinterface
`default_nettype wire

>>> rtl/lphs_hash.sv
`default_nettype none
// Sequenced hash: one shared 32x32 multiplier, xor-shift and byte steps,
// then a reduction of the hash to a slot index.
module lphs_hash import lphs_pkg::*; #(
    parameter int TABLE_SIZE = 1024,
    parameter int AW         = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_sel,
    input  wire logic [63:0]   i_key,
    output logic               o_done,
    output logic [AW-1:0]      o_index
);
    localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    // 2^32 mod TABLE_SIZE, and floor(2^32 / TABLE_SIZE)
    localparam logic [63:0] C_FOLD  = (64'd1 << 32) % 64'(TABLE_SIZE);
    localparam logic [63:0] C_RECIP = (64'd1 << 32) / 64'(TABLE_SIZE);

    t_hash_state  r_state, n_state;
    logic [1:0]   r_sel, n_sel;
    logic [63:0]  r_v, n_v;
    logic [63:0]  r_k, n_k;
    logic [63:0]  r_b, n_b;
    logic [63:0]  r_acc, n_acc;
    logic [63:0]  r_prod;
    logic [1:0]   r_mph, n_mph;
    logic [1:0]   r_step, n_step;
    logic [5:0]   r_cnt, n_cnt;
    logic [AW-1:0] r_rem, n_rem;

    logic [31:0]  mul_a, mul_b;

    // partial products: lo*lo, lo*hi, hi*lo (low 64 bits of the product only)
    always_comb begin
        case (r_mph)
            2'd0: begin
                mul_a = r_v[31:0];
                mul_b = r_b[31:0];
            end
            2'd1: begin
                mul_a = r_v[31:0];
                mul_b = r_b[63:32];
            end
            default: begin
                mul_a = r_v[63:32];
                mul_b = r_b[31:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_v     = r_v;
        n_k     = r_k;
        n_b     = r_b;
        n_acc   = r_acc;
        n_mph   = r_mph;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        o_done  = 1'b0;
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_sel  = i_sel;
                    n_k    = i_key;
                    n_v    = i_key;
                    n_step = 2'd0;
                    n_cnt  = 6'd0;
                    n_mph  = 2'd0;
                    n_rem  = '0;
                    case (i_sel)
                        HS_IDENT: n_state = H_MOD;
                        HS_FIB: begin
                            n_b     = C_FIB;
                            n_state = H_MUL;
                        end
                        HS_MURMUR: n_state = H_XS;
                        default: begin
                            n_v     = C_FNV_OFF;
                            n_state = H_FNVX;
                        end
                    endcase
                end
            end
            H_XS: begin
                n_v    = r_v ^ (r_v >> MUR_SHIFT);
                n_step = r_step + 2'd1;
                if (r_step == 2'd2) begin
                    n_state = H_MOD;
                end else begin
                    n_b     = (r_step == 2'd0) ? C_MUR1 : C_MUR2;
                    n_state = H_MUL;
                end
            end
            H_FNVX: begin
                n_v     = r_v ^ {56'd0, r_k[7:0]};
                n_k     = r_k >> 8;
                n_b     = C_FNV_PRM;
                n_state = H_MUL;
            end
            H_MUL: begin
                n_mph = r_mph + 2'd1;
                case (r_mph)
                    2'd0: n_acc = r_acc;
                    2'd1: n_acc = r_prod;
                    2'd2: n_acc = r_acc + {r_prod[31:0], 32'd0};
                    default: begin
                        n_v   = r_acc + {r_prod[31:0], 32'd0};
                        n_mph = 2'd0;
                        case (r_sel)
                            HS_MURMUR: n_state = H_XS;
                            HS_FNV: begin
                                n_cnt = r_cnt + 6'd1;
                                if (r_cnt == 6'd7) begin
                                    n_cnt   = 6'd0;
                                    n_state = H_MOD;
                                end else begin
                                    n_state = H_FNVX;
                                end
                            end
                            default: n_state = H_MOD;
                        endcase
                    end
                endcase
            end
            H_MOD: begin
                n_step = 2'd0;
                if (IS_POW2) begin
                    n_rem   = r_v[AW-1:0];
                    n_state = H_DONE;
                end else if (r_v[63:32] != 32'd0) begin
                    // fold the top word back in: 2^32 is congruent to C_FOLD
                    n_b     = C_FOLD;
                    n_mph   = 2'd2;
                    n_state = H_FOLD;
                end else begin
                    n_b     = C_RECIP;
                    n_mph   = 2'd0;
                    n_state = H_RCP;
                end
            end
            H_FOLD: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd1) begin
                    n_v     = r_prod + {32'd0, r_v[31:0]};
                    n_state = H_MOD;
                end
            end
            H_RCP: begin
                // quotient estimate, low by at most one
                n_step = r_step + 2'd1;
                if (r_step == 2'd1) begin
                    n_k     = r_v;
                    n_v     = {32'd0, r_prod[63:32]};
                    n_b     = 64'(TABLE_SIZE);
                    n_step  = 2'd0;
                    n_state = H_QM;
                end
            end
            H_QM: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd1) begin
                    n_v     = {32'd0, r_k[31:0] - r_prod[31:0]};
                    n_state = H_FIX;
                end
            end
            H_FIX: begin
                n_rem   = (r_v >= 64'(TABLE_SIZE)) ? AW'(r_v - 64'(TABLE_SIZE)) : AW'(r_v);
                n_state = H_DONE;
            end
            H_DONE: begin
                o_done  = 1'b1;
                n_state = H_IDLE;
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sel  <= n_sel;
        r_v    <= n_v;
        r_k    <= n_k;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_mph  <= n_mph;
        r_step <= n_step;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
    end

    assign o_index = r_rem;

endmodule
`default_nettype wire

>>> rtl/lphs_table.sv
`default_nettype none
// Slot storage: mark, key and payload arrays, one write and one read port.
module lphs_table import lphs_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int SW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_mark_en,
    input  wire logic          i_wr_data_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [1:0]    i_wr_mark,
    input  wire logic [63:0]   i_wr_key,
    input  wire logic [SW-1:0] i_wr_pay,
    output logic [1:0]         o_rd_mark,
    output logic [63:0]        o_rd_key,
    output logic [SW-1:0]      o_rd_pay
);
    logic [1:0]    r_mark_mem [DEPTH];
    logic [63:0]   r_key_mem  [DEPTH];
    logic [SW-1:0] r_pay_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_mark_en) begin
            r_mark_mem[i_wr_addr] <= i_wr_mark;
        end
        if (i_wr_data_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_pay_mem[i_wr_addr] <= i_wr_pay;
        end
        o_rd_mark <= r_mark_mem[i_rd_addr];
        o_rd_key  <= r_key_mem[i_rd_addr];
        o_rd_pay  <= r_pay_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

>>> rtl/linear_probe_hash_set.sv
// Open-addressed hash set of 64-bit keys with payloads, linear probing.
// i_req (valid/ready): req_type find/insert/remove/clear, key, payload.
// o_rsp (valid/ready): status, found_payload, entry_count; one per request.
// i_cfg_we/i_cfg_wdata: hash select (0 identity, 1 Fibonacci, 2 Murmur3,
// 3 FNV-1a), write only while idle; resets to Murmur3.
// One request at a time; ready is high only while the sequencer is idle.
// Each request runs the hash, the reduction, then one probe per slot walked:
//   hash: Fibonacci, Murmur3 and FNV-1a run on the one shared 32x32
//   multiplier, identity passes the key through;
//   reduction: the low index bits for a power-of-two TABLE_SIZE, else
//   32-bit word folds, then a reciprocal multiply and one correction;
//   each probe is one read of the slot memories plus one evaluate step.
// Clear sweeps every slot, one per cycle.
// After reset the same sweep runs before ready rises.
// A finished response sits in an output register; a new request is taken
// while it waits. If the receiver stalls, the next response holds in the
// done state until the output register frees.
`default_nettype none
module linear_probe_hash_set import lphs_pkg::*; #(
    parameter int TABLE_SIZE   = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lphs_req_if.sink      i_req,
    lphs_rsp_if.source    o_rsp,
    input  wire logic     i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata
);
    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);
    // only the low 32 payload bits ever arrive
    localparam int SW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

    t_state          r_state, n_state;
    t_req            r_req, n_req;
    logic [63:0]     r_key, n_key;
    logic [SW-1:0]   r_pay, n_pay;
    logic [AW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_n, n_n;
    logic            r_have_dead, n_have_dead;
    logic [AW-1:0]   r_tgt, n_tgt;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_hash_sel;
    t_status         r_status, n_status;
    logic [PAY_W-1:0] r_found, n_found;
    logic            r_clr_rsp, n_clr_rsp;
    logic            r_out_valid, n_out_valid;
    t_status         r_out_status, n_out_status;
    logic [PAY_W-1:0] r_out_found, n_out_found;
    logic [CW-1:0]   r_out_count, n_out_count;

    logic            hash_start, hash_done;
    logic [AW-1:0]   hash_idx;
    logic            wr_mark_en, wr_data_en;
    logic [AW-1:0]   wr_addr;
    logic [1:0]      wr_mark;
    logic [1:0]      rd_mark;
    logic [63:0]     rd_key;
    logic [SW-1:0]   rd_pay;
    logic            slot_match, slot_dead, last_probe, accept;

    lphs_hash #(.TABLE_SIZE(TABLE_SIZE), .AW(AW)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_sel   (r_hash_sel),
        .i_key   (r_key),
        .o_done  (hash_done),
        .o_index (hash_idx)
    );

    lphs_table #(.DEPTH(TABLE_SIZE), .AW(AW), .SW(SW)) u_table (
        .i_clk        (i_clk),
        .i_rd_addr    (r_idx),
        .i_wr_mark_en (wr_mark_en),
        .i_wr_data_en (wr_data_en),
        .i_wr_addr    (wr_addr),
        .i_wr_mark    (wr_mark),
        .i_wr_key     (r_key),
        .i_wr_pay     (r_pay),
        .o_rd_mark    (rd_mark),
        .o_rd_key     (rd_key),
        .o_rd_pay     (rd_pay)
    );

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign slot_match  = (rd_mark == MARK_USED) && (rd_key == r_key);
    assign slot_dead   = (rd_mark != MARK_USED) && (rd_mark != MARK_EMPTY);
    assign last_probe  = (r_n == CW'(TABLE_SIZE - 1));

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_key        = r_key;
        n_pay        = r_pay;
        n_idx        = r_idx;
        n_n          = r_n;
        n_have_dead  = r_have_dead;
        n_tgt        = r_tgt;
        n_count      = r_count;
        n_status     = r_status;
        n_found      = r_found;
        n_clr_rsp    = r_clr_rsp;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        hash_start   = 1'b0;
        wr_mark_en   = 1'b0;
        wr_data_en   = 1'b0;
        wr_addr      = r_idx;
        wr_mark      = MARK_EMPTY;
        case (r_state)
            S_CLEAR: begin
                // sweep: one slot per cycle back to empty
                wr_mark_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_count = '0;
                    n_idx   = '0;
                    if (r_clr_rsp) begin
                        n_clr_rsp = 1'b0;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_req    = t_req'(i_req.req_type);
                    n_key    = i_req.key;
                    n_pay    = SW'(i_req.payload);
                    n_status = ST_OK;
                    n_found  = '0;
                    if (t_req'(i_req.req_type) == REQ_CLEAR) begin
                        n_idx     = '0;
                        n_clr_rsp = 1'b1;
                        n_state   = S_CLEAR;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                // key register holds the new key here, so start is issued now
                hash_start = (r_n == '0) && !r_have_dead;
                n_n        = CW'(1);
                if (hash_done) begin
                    n_idx       = hash_idx;
                    n_n         = '0;
                    n_have_dead = 1'b0;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_DONE;
                if (rd_mark == MARK_EMPTY) begin
                    if (r_req == REQ_INSERT) begin
                        wr_mark_en = 1'b1;
                        wr_data_en = 1'b1;
                        wr_mark    = MARK_USED;
                        wr_addr    = r_have_dead ? r_tgt : r_idx;
                        n_count    = r_count + CW'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else if (slot_match) begin
                    case (r_req)
                        REQ_FIND: n_found = PAY_W'(rd_pay);
                        REQ_REMOVE: begin
                            wr_mark_en = 1'b1;
                            wr_mark    = MARK_DEAD;
                            n_count    = r_count - CW'(1);
                        end
                        default: n_status = ST_DUP;
                    endcase
                end else begin
                    if (slot_dead && !r_have_dead) begin
                        n_have_dead = 1'b1;
                        n_tgt       = r_idx;
                    end
                    if (last_probe) begin
                        // whole table walked without an empty slot
                        if (r_req == REQ_INSERT) begin
                            if (r_have_dead || slot_dead) begin
                                wr_mark_en = 1'b1;
                                wr_data_en = 1'b1;
                                wr_mark    = MARK_USED;
                                wr_addr    = r_have_dead ? r_tgt : r_idx;
                                n_count    = r_count + CW'(1);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end else begin
                        n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + AW'(1);
                        n_n     = r_n + CW'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_count  = r_count;
                    n_n          = '0;
                    n_have_dead  = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_n         <= '0;
            r_have_dead <= 1'b0;
            r_count     <= '0;
            r_clr_rsp   <= 1'b0;
            r_out_valid <= 1'b0;
            r_hash_sel  <= HS_RESET;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_have_dead <= n_have_dead;
            r_count     <= n_count;
            r_clr_rsp   <= n_clr_rsp;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_hash_sel <= i_cfg_wdata;
            end
        end
        r_req        <= n_req;
        r_key        <= n_key;
        r_pay        <= n_pay;
        r_tgt        <= n_tgt;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.found_payload = r_out_found;
    assign o_rsp.entry_count   = COUNT_W'(r_out_count);

    // occupancy can never pass the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_SIZE))
        else $error("occupancy above table size");

    // the last slot of a sweep leaves the table empty
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_idx == LAST_IDX) |=> (r_count == '0))
        else $error("count not zero after clear sweep");

    // payload only comes back on a successful request
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.found_payload == '0))
        else $error("payload returned with failing status");

    // an accepted request always leaves idle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer idle");

endmodule
`default_nettype wire

>>> tb/linear_probe_hash_set_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for linear_probe_hash_set. A behavioral copy of the set
// (marks, keys, payloads, occupancy, hash select) predicts each response.
// Directed tests cover collisions, tombstones, a full table and clear. Random
// phases then sweep every hash select under three idle/stall mixes.
module linear_probe_hash_set_tb;
    import lphs_pkg::*;

    localparam int SLOTS       = 1024;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAY_W-1:0]    found_payload;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_wdata;

    lphs_req_if req_if ();
    lphs_rsp_if rsp_if ();

    linear_probe_hash_set uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // shadow copy of the table
    logic [1:0]         shadow_mark [SLOTS];
    logic [KEY_W-1:0]   shadow_key  [SLOTS];
    logic [PAY_W-1:0]   shadow_pay  [SLOTS];
    logic [COUNT_W-1:0] shadow_count;
    logic [1:0]         shadow_hash_sel;

    rsp_t pending_rsp_q[$];
    int   mismatch_cnt;
    int   cycle_cnt;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic [KEY_W-1:0] key_pool [48];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hash of the key as the set selects it; home slot is the low bits.
    function automatic logic [KEY_W-1:0] slot_hash(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        case (shadow_hash_sel)
            HS_FIB: h = k * C_FIB;
            HS_MURMUR: begin
                h = k ^ (k >> MUR_SHIFT);
                h = h * C_MUR1;
                h = h ^ (h >> MUR_SHIFT);
                h = h * C_MUR2;
                h = h ^ (h >> MUR_SHIFT);
            end
            HS_FNV: begin
                h = C_FNV_OFF;
                for (int b = 0; b < 8; b++) begin
                    h = h ^ {56'd0, k[8*b +: 8]};
                    h = h * C_FNV_PRM;
                end
            end
            default: h = k;
        endcase
        return h;
    endfunction

    // Apply one request to the shadow table and return the expected response.
    function automatic rsp_t hash_set_apply(input t_req r, input logic [KEY_W-1:0] k,
                                            input logic [PAY_W-1:0] p);
        rsp_t o;
        int   idx;
        int   hit;
        int   dead_at;
        bit   saw_empty;
        o = '0;
        idx = int'(slot_hash(k) % SLOTS);
        hit = -1;
        dead_at = -1;
        saw_empty = 1'b0;
        if (r != REQ_CLEAR) begin
            // one walk serves all three: stop at empty, note first tombstone
            for (int n = 0; n < SLOTS; n++) begin
                if (shadow_mark[idx] == MARK_EMPTY) begin
                    saw_empty = 1'b1;
                    break;
                end
                if (shadow_mark[idx] == MARK_USED) begin
                    if (shadow_key[idx] == k) begin
                        hit = idx;
                        break;
                    end
                end else if (dead_at < 0) begin
                    dead_at = idx;
                end
                idx = (idx + 1) % SLOTS;
            end
        end
        case (r)
            REQ_FIND: begin
                if (hit >= 0) o.found_payload = shadow_pay[hit];
                else o.status = ST_NOT_FOUND;
            end
            REQ_INSERT: begin
                if (hit >= 0) begin
                    o.status = ST_DUP;
                end else if (dead_at < 0 && !saw_empty) begin
                    o.status = ST_FULL;
                end else begin
                    if (dead_at < 0) dead_at = idx;
                    shadow_mark[dead_at] = MARK_USED;
                    shadow_key[dead_at]  = k;
                    shadow_pay[dead_at]  = p;
                    shadow_count++;
                end
            end
            REQ_REMOVE: begin
                if (hit >= 0) begin
                    shadow_mark[hit] = MARK_DEAD;
                    shadow_count--;
                end else begin
                    o.status = ST_NOT_FOUND;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) shadow_mark[i] = MARK_EMPTY;
                shadow_count = '0;
            end
        endcase
        o.entry_count = shadow_count;
        return o;
    endfunction

    // Response side: random back-pressure, compare each transaction in order.
    always @(posedge i_clk) begin
        rsp_t exp_rsp;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_rsp_q.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("unexpected response: st=%0d pay=%h cnt=%0d",
                                 rsp_if.status, rsp_if.found_payload, rsp_if.entry_count);
                end else begin
                    exp_rsp = pending_rsp_q.pop_front();
                    if (rsp_if.status !== exp_rsp.status
                            || rsp_if.found_payload !== exp_rsp.found_payload
                            || rsp_if.entry_count !== exp_rsp.entry_count) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < MAX_REPORTS)
                            $display("response mismatch: exp st=%0d pay=%h cnt=%0d, got st=%0d pay=%h cnt=%0d",
                                     exp_rsp.status, exp_rsp.found_payload, exp_rsp.entry_count,
                                     rsp_if.status, rsp_if.found_payload, rsp_if.entry_count);
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Send one request; valid stays high after acceptance so back-to-back
    // transactions need no extra edge.
    task automatic send_req(input t_req r, input logic [KEY_W-1:0] k,
                            input logic [PAY_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= r;
        req_if.key      <= k;
        req_if.payload  <= p;
        do @(posedge i_clk); while (!req_if.ready);
        pending_rsp_q.push_back(hash_set_apply(r, k, p));
    endtask

    // Sender holds off until every outstanding response is back.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_hash_sel(input logic [1:0] sel);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sel;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_hash_sel = sel;
    endtask

    // Reset default (Murmur3): basic find/insert/remove and clear, field extremes.
    task automatic test_basic_ops();
        send_req(REQ_FIND, 64'd0, 32'd0);
        send_req(REQ_REMOVE, '1, 32'd0);
        send_req(REQ_INSERT, 64'd0, 32'd0);
        send_req(REQ_INSERT, '1, '1);
        send_req(REQ_INSERT, '1, 32'h1234_5678);
        send_req(REQ_FIND, '1, 32'd0);
        send_req(REQ_FIND, 64'd0, '1);
        send_req(REQ_REMOVE, 64'd0, 32'd0);
        send_req(REQ_FIND, 64'd0, 32'd0);
        send_req(REQ_REMOVE, 64'd0, 32'd0);
        send_req(REQ_CLEAR, 64'hA5A5_5A5A_0F0F_F0F0, 32'hDEAD_BEEF);
        send_req(REQ_FIND, '1, 32'd0);
    endtask

    // Identity hash: one cluster, tombstone reuse, probing past tombstones, a duplicate, clear.
    task automatic test_collisions();
        write_hash_sel(HS_IDENT);
        send_req(REQ_INSERT, 64'd1023, 32'h11);          // last slot, wraps next
        send_req(REQ_INSERT, 64'd1023 + 1024, 32'h22);
        send_req(REQ_INSERT, 64'd1023 + 2048, 32'h33);
        send_req(REQ_REMOVE, 64'd1023 + 1024, 32'd0);
        send_req(REQ_FIND, 64'd1023 + 2048, 32'd0);      // walks past tombstone
        send_req(REQ_INSERT, 64'd1023 + 2048, 32'h44);   // duplicate beyond tombstone
        send_req(REQ_INSERT, 64'd1023 + 3072, 32'h55);   // reuses tombstone
        send_req(REQ_FIND, 64'd1023 + 3072, 32'd0);
        send_req(REQ_CLEAR, 64'd0, 32'd0);
    endtask

    // Fill every slot, then hit the full case, tombstone reuse and clear.
    task automatic test_table_full();
        for (int i = 0; i < SLOTS; i++)
            send_req(REQ_INSERT, 64'(i) | (64'($urandom) << 32) & ~64'h3FF, $urandom);
        send_req(REQ_INSERT, 64'h8000_0000_0000_0005, 32'h77);
        send_req(REQ_FIND, 64'h8000_0000_0000_0005, 32'd0);
        drain();
        send_req(REQ_REMOVE, shadow_key[7], 32'd0);
        send_req(REQ_INSERT, 64'h8000_0000_0000_0005, 32'h77);
        send_req(REQ_FIND, 64'h8000_0000_0000_0005, 32'd0);
        send_req(REQ_INSERT, 64'h8000_0000_0000_0005, 32'h78);
        send_req(REQ_CLEAR, 64'd0, 32'd0);
    endtask

    // Random phase: mostly pool keys so hits, duplicates and removes happen.
    task automatic test_random(input logic [1:0] sel, input int n_items);
        logic [KEY_W-1:0] k;
        int pick;
        t_req r;
        write_hash_sel(sel);
        for (int i = 0; i < 48; i++)
            key_pool[i] = (i < 16) ? (64'({$urandom, $urandom}) & ~64'h3FF) | 64'd17 + 64'(i)
                                  : {$urandom, $urandom};
        // colliding block for identity: same low bits, different high bits
        for (int i = 0; i < 8; i++) key_pool[i] = (64'(i) << 40) | 64'd200;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (pick < 2)       r = REQ_CLEAR;
            else if (pick < 35) r = REQ_FIND;
            else if (pick < 72) r = REQ_INSERT;
            else                r = REQ_REMOVE;
            if ($urandom_range(99) < 70) k = key_pool[$urandom_range(47)];
            else k = {$urandom, $urandom};
            send_req(r, k, $urandom);
        end
    endtask

    task automatic test_random_mix(input int s_idle, input int r_stall);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        test_random(HS_FNV, 70);
        test_random(HS_IDENT, 70);
        test_random(HS_FIB, 70);
        test_random(HS_MURMUR, 70);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_FIND;
        req_if.key       = '0;
        req_if.payload   = '0;
        mismatch_cnt     = 0;
        cycle_cnt        = 0;
        send_idle_pct    = 27;
        recv_stall_pct   = 64;
        shadow_count     = '0;
        shadow_hash_sel  = HS_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_mark[i] = MARK_EMPTY;
            shadow_key[i]  = '0;
            shadow_pay[i]  = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_collisions();
        test_table_full();
        test_random_mix(27, 64);
        test_random_mix(64, 27);
        test_random_mix(0, 0);

        drain();
        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/lphs_pkg.sv
rtl/lphs_if.sv
rtl/lphs_hash.sv
rtl/lphs_table.sv
rtl/linear_probe_hash_set.sv
tb/linear_probe_hash_set_tb.sv
